>>> design/assert_macros.svh
// Assertion macros shared by the oscillator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold a fixed number of cycles after the antecedent.
`define ASSERT_DELAY(label, clk, rst_n, ante, n, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

>>> design/mlfo_pkg.sv
// Types, constants and sine table generation for the morphing oscillator.
package mlfo_pkg;

    localparam int PHASE_W    = 32;
    localparam int SAMPLE_W   = 16;
    localparam int MORPH_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam int Q_W        = SAMPLE_W + 1;
    localparam int VAL_W      = SAMPLE_W + 2;
    localparam int PROD_W     = 2 * VAL_W;
    localparam int ACC_W      = 34;

    localparam logic [MORPH_W-1:0] MORPH_FULL = 17'd65536;

    localparam logic [63:0] Q30         = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q       = 64'd1 << (SAMPLE_W - 1);
    localparam logic [63:0] MAX_Q       = ONE_Q - 64'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_SEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MORPH_AMT   = 2'd2;

    typedef enum logic [2:0] {
        SH_SINE   = 3'd0,
        SH_TRI    = 3'd1,
        SH_SAW_UP = 3'd2,
        SH_SAW_DN = 3'd3,
        SH_SQUARE = 3'd4,
        SH_RANDOM = 3'd5
    } shape_t;

    typedef enum logic [1:0] {
        MS_RND  = 2'd0,
        MS_BASE = 2'd1,
        MS_NEXT = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     cap_rnd;
        logic     acc_init;
        logic     acc_add;
        logic     load_out;
        mul_sel_t mul_sel;
    } ctrl_t;

    typedef logic signed [SAMPLE_W-1:0] sine_table_t [SINE_DEPTH];

    // Quarter-wave sine in Q1.15 from an odd Taylor series in truncated Q30.
    function automatic logic [63:0] quarter_sine(input logic [63:0] rem);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        x  = (HALF_PI_Q30 * rem) / SINE_DEPTH;
        x2 = (x * x) >> 30;
        t  = Q30;
        t  = Q30 - ((x2 * t) >> 30) / 110;
        t  = Q30 - ((x2 * t) >> 30) / 72;
        t  = Q30 - ((x2 * t) >> 30) / 42;
        t  = Q30 - ((x2 * t) >> 30) / 20;
        t  = Q30 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        r  = (s * ONE_Q + (Q30 >> 1)) >> 30;
        return (r > MAX_Q) ? MAX_Q : r;
    endfunction

    function automatic sine_table_t sine_table_init();
        sine_table_t tbl;
        logic [63:0] a;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] v;
        for (int i = 0; i < SINE_DEPTH; i++)
        begin
            a    = 64'(4 * i);
            quad = a / SINE_DEPTH;
            rem  = a - quad * SINE_DEPTH;
            v    = quad[0] ? quarter_sine(64'(SINE_DEPTH) - rem) : quarter_sine(rem);
            tbl[i] = quad[1] ? -SAMPLE_W'(v) : SAMPLE_W'(v);
        end
        return tbl;
    endfunction

endpackage

>>> design/mlfo_if.sv
// Request channel interfaces for the oscillator input and output.
interface mlfo_in_if
    import mlfo_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] random_sample;

    modport source (output valid, output random_sample, input ready);
    modport sink   (input valid, input random_sample, output ready);
endinterface

interface mlfo_out_if
    import mlfo_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] lfo_value;
    logic                       phase_wrapped;

    modport source (output valid, output lfo_value, output phase_wrapped, input ready);
    modport sink   (input valid, input lfo_value, input phase_wrapped, output ready);
endinterface

>>> design/morphing_lfo.sv
// Top level of the morphing low-frequency oscillator.
// Each request on in_ch is one audio tick and carries random_sample, which is
// only used when the phase wraps while the random shape is selected. Each tick
// returns exactly one request on out_ch with lfo_value (Q1.15) and
// phase_wrapped. Both channels transfer when valid and ready are high together.
// Configuration is written through cfg_we, cfg_index and cfg_data: index 0
// phase step, 1 shape select, 2 morph amount. The user must write it only
// while the block is idle; the block itself does not enforce this. In a tick
// the request is taken in the idle step while the random ramp product is
// formed and the sine ROM is read, then the base and next shapes pass in turn
// through the one shared multiplier into the accumulator, and the last step
// loads the output register and advances the phase. in_ch.ready is high only
// in the idle step, so no tick is accepted until the last one is loaded.
// If the receiver stalls, a finished result waits in the output register and
// the next request is still accepted; that tick then holds in its last step
// until the output register frees up.
// Reset clears the phase, the held random values and all configuration.
module morphing_lfo
    import mlfo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    mlfo_in_if.sink               in_ch,
    mlfo_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_t                      ctrl;
    logic                       in_ready;
    logic                       out_free;
    logic [SINE_AW-1:0]         sine_addr;
    logic signed [SAMPLE_W-1:0] sine_val;

    assign in_ch.ready = in_ready;

    mlfo_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    mlfo_sine_rom u_rom (
        .clk   (clk),
        .rd_en (ctrl.cap_rnd),
        .addr  (sine_addr),
        .data  (sine_val)
    );

    mlfo_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .ctrl          (ctrl),
        .random_sample (in_ch.random_sample),
        .sine_val      (sine_val),
        .out_ready     (out_ch.ready),
        .out_free      (out_free),
        .sine_addr     (sine_addr),
        .out_valid     (out_ch.valid),
        .lfo_value     (out_ch.lfo_value),
        .phase_wrapped (out_ch.phase_wrapped)
    );

endmodule

>>> design/mlfo_sine_rom.sv
// Full-cycle sine lookup ROM with a registered read port.
module mlfo_sine_rom
    import mlfo_pkg::*;
(
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [SINE_AW-1:0]         addr,
    output logic signed [SAMPLE_W-1:0] data
);

    localparam sine_table_t SINE_ROM = sine_table_init();

    logic signed [SAMPLE_W-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= SINE_ROM[addr];
        end
    end

    assign data = data_reg;

endmodule

>>> design/mlfo_seq.sv
// Sequencer that steps the shared multiplier through one tick.
module mlfo_seq
    import mlfo_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  logic  out_free,
    output logic  in_ready,
    output ctrl_t ctrl
);
`include "assert_macros.svh"

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_BASE = 4'b0010,
        ST_NEXT = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next    = state_reg;
        ctrl.cap_rnd  = 1'b0;
        ctrl.acc_init = 1'b0;
        ctrl.acc_add  = 1'b0;
        ctrl.load_out = 1'b0;
        ctrl.mul_sel  = MS_RND;
        unique case (state_reg)
            ST_IDLE:
            begin
                // The random ramp product is formed while waiting for a request.
                ctrl.cap_rnd = in_fire;
                if (in_fire)
                begin
                    state_next = ST_BASE;
                end
            end
            ST_BASE:
            begin
                ctrl.mul_sel  = MS_BASE;
                ctrl.acc_init = 1'b1;
                state_next    = ST_NEXT;
            end
            ST_NEXT:
            begin
                ctrl.mul_sel = MS_NEXT;
                ctrl.acc_add = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                ctrl.load_out = out_free;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_DELAY(a_tick_latency, clk, rst_n, in_fire, 3, state_reg == ST_DONE, "tick did not reach the result step in three cycles")
    `ASSERT_NEXT(a_stall_hold, clk, rst_n, (state_reg == ST_DONE) && !out_free, state_reg == ST_DONE, "result step left while the output was blocked")
    `ASSERT_IMPLIES(a_state_onehot, clk, rst_n, 1'b1, $onehot(state_reg), "sequencer state is not one-hot")

endmodule

>>> design/mlfo_datapath.sv
// Configuration, phase, held random values and the shared multiply-accumulate path.
module mlfo_datapath
    import mlfo_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  ctrl_t                      ctrl,
    input  logic signed [SAMPLE_W-1:0] random_sample,
    input  logic signed [SAMPLE_W-1:0] sine_val,
    input  logic                       out_ready,
    output logic                       out_free,
    output logic [SINE_AW-1:0]         sine_addr,
    output logic                       out_valid,
    output logic signed [SAMPLE_W-1:0] lfo_value,
    output logic                       phase_wrapped
);
`include "assert_macros.svh"

    localparam logic signed [VAL_W-1:0] ONE_V   = 18'sd32768;
    localparam logic signed [VAL_W-1:0] THREE_V = 18'sd98304;
    localparam logic signed [VAL_W-1:0] MAX_V   = 18'sd32767;
    localparam logic signed [VAL_W-1:0] MIN_V   = -18'sd32768;

    logic [PHASE_W-1:0]         step_reg;
    shape_t                     shape_reg;
    logic [MORPH_W-1:0]         morph_reg;
    logic [PHASE_W-1:0]         phase_reg;
    logic signed [SAMPLE_W-1:0] last_reg;
    logic signed [SAMPLE_W-1:0] next_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic signed [PROD_W-1:0]   rnd_prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] lfo_reg;
    logic                       wrap_reg;

    logic [Q_W-1:0]             q;
    logic signed [Q_W-1:0]      rnd_diff;
    logic signed [VAL_W-1:0]    rnd_val;
    shape_t                     next_shape;
    logic signed [SAMPLE_W-1:0] base_val;
    logic signed [SAMPLE_W-1:0] nxt_val;
    logic signed [VAL_W-1:0]    mul_a;
    logic signed [VAL_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic [PHASE_W:0]           phase_sum;
    logic signed [VAL_W-1:0]    mix;
    logic [2:0]                 shape_wr;
    logic [MORPH_W-1:0]         morph_wr;

    function automatic logic signed [SAMPLE_W-1:0] sat_val(input logic signed [VAL_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > MAX_V)
        begin
            r = SAMPLE_W'(MAX_V);
        end
        else if (v < MIN_V)
        begin
            r = SAMPLE_W'(MIN_V);
        end
        else
        begin
            r = SAMPLE_W'(v);
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] shape_eval(
        input shape_t                     shp,
        input logic [Q_W-1:0]             qv,
        input logic signed [SAMPLE_W-1:0] sv,
        input logic signed [VAL_W-1:0]    rv
    );
        logic signed [VAL_W-1:0] v;
        logic signed [VAL_W-1:0] qs;
        logic signed [VAL_W-1:0] hs;
        qs = signed'({1'b0, qv});
        hs = signed'({2'b00, qv[Q_W-1:1]});
        unique case (shp)
            SH_SINE:   v = VAL_W'(sv);
            SH_TRI:    v = qv[Q_W-1] ? (THREE_V - qs) : (qs - ONE_V);
            SH_SAW_UP: v = hs - ONE_V;
            SH_SAW_DN: v = ONE_V - hs;
            SH_SQUARE: v = qv[Q_W-1] ? MIN_V : MAX_V;
            SH_RANDOM: v = rv;
            default:   v = rv;
        endcase
        return sat_val(v);
    endfunction

    assign q         = phase_reg[PHASE_W-1 -: Q_W];
    assign sine_addr = phase_reg[PHASE_W-1 -: SINE_AW];
    assign rnd_diff  = Q_W'(next_reg) - Q_W'(last_reg);
    // Random ramp: last plus the floored fraction of the step toward next.
    assign rnd_val   = VAL_W'(last_reg) + VAL_W'(rnd_prod_reg >>> (Q_W));

    assign next_shape = (shape_reg == SH_RANDOM) ? SH_SINE : shape_t'(shape_reg + 3'd1);
    assign base_val   = shape_eval(shape_reg, q, sine_val, rnd_val);
    assign nxt_val    = shape_eval(next_shape, q, sine_val, rnd_val);

    always_comb
    begin
        unique case (ctrl.mul_sel)
            MS_RND:
            begin
                mul_a = VAL_W'(rnd_diff);
                mul_b = signed'({1'b0, q});
            end
            MS_BASE:
            begin
                mul_a = VAL_W'(base_val);
                mul_b = signed'({1'b0, MORPH_W'(MORPH_FULL - morph_reg)});
            end
            MS_NEXT:
            begin
                mul_a = VAL_W'(nxt_val);
                mul_b = signed'({1'b0, morph_reg});
            end
            default:
            begin
                mul_a = VAL_W'(rnd_diff);
                mul_b = signed'({1'b0, q});
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign phase_sum = {1'b0, phase_reg} + {1'b0, step_reg};
    assign mix       = VAL_W'(acc_reg >>> 16);
    assign shape_wr  = cfg_data[2:0];
    assign morph_wr  = cfg_data[MORPH_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            shape_reg     <= SH_SINE;
            morph_reg     <= '0;
            phase_reg     <= '0;
            last_reg      <= '0;
            next_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PHASE_STEP: step_reg <= cfg_data[PHASE_W-1:0];
                    CFG_SHAPE_SEL:
                        shape_reg <= (shape_wr > SH_RANDOM) ? SH_RANDOM : shape_t'(shape_wr);
                    CFG_MORPH_AMT:
                        morph_reg <= (morph_wr > MORPH_FULL) ? MORPH_FULL : morph_wr;
                    default: ;
                endcase
            end
            if (ctrl.load_out)
            begin
                phase_reg     <= phase_sum[PHASE_W-1:0];
                out_valid_reg <= 1'b1;
                if (phase_sum[PHASE_W] && (shape_reg == SH_RANDOM))
                begin
                    last_reg <= next_reg;
                    next_reg <= sample_reg;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.cap_rnd)
        begin
            sample_reg   <= random_sample;
            rnd_prod_reg <= mul_p;
        end
        if (ctrl.acc_init)
        begin
            acc_reg <= ACC_W'(mul_p) + ACC_W'(32768);
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= acc_reg + ACC_W'(mul_p);
        end
        if (ctrl.load_out)
        begin
            lfo_reg  <= sat_val(mix);
            wrap_reg <= phase_sum[PHASE_W];
        end
    end

    assign out_free      = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign lfo_value     = lfo_reg;
    assign phase_wrapped = wrap_reg;

    `ASSERT_NEXT(a_phase_hold, clk, rst_n, !ctrl.load_out, $stable(phase_reg), "phase moved outside a result load")
    `ASSERT_NEXT(a_rnd_shift, clk, rst_n, ctrl.load_out && phase_sum[PHASE_W] && (shape_reg == SH_RANDOM), last_reg == $past(next_reg), "held random values did not shift on wrap")
    `ASSERT_NEXT(a_out_load, clk, rst_n, ctrl.load_out, out_valid_reg, "loaded result is not presented")

endmodule
